// File: hdl/pmi_pkg.sv
// Shared types and constants for the parabolic minimum interpolator.
package pmi_pkg;

  localparam int VAL_W  = 32;  // curve sample width
  localparam int KIDX_W = 16;  // widest sample index the block supports
  localparam int IDX_W  = 8;   // width of the min_index result field
  localparam int REF_W  = 17;  // width of the refined_index result field

  // One closed sequence, handed from the front end to the divider back end.
  typedef struct packed {
    logic [VAL_W-1:0]  val_before;  // sample left of the minimum
    logic [VAL_W-1:0]  val_min;     // the minimum itself
    logic [VAL_W-1:0]  val_after;   // sample right of the minimum
    logic [KIDX_W-1:0] min_pos;     // index of the first strict minimum
    logic              pending;     // minimum had no right neighbor
    logic              overflow;    // items past the length limit were dropped
  } trough_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SETUP,
    BK_PREP,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

// File: hdl/pmi_front.sv
// Front end: tracks the first strict minimum and its neighbors over a sequence.
module pmi_front #(
  parameter int MAX_LEN = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [pmi_pkg::VAL_W-1:0] curve_value,
  input  logic                      last,
  input  logic                      q_full,
  output logic                      rec_push,
  output pmi_pkg::trough_t          rec
);
  import pmi_pkg::*;

  localparam int PCNT_W = $clog2(MAX_LEN + 1);
  localparam int POS_W  = $clog2(MAX_LEN);

  logic [PCNT_W-1:0] position, position_next;
  logic [POS_W-1:0]  best_pos, best_pos_next;
  logic [VAL_W-1:0]  best_val, best_val_next;
  logic [VAL_W-1:0]  before_val, before_val_next;
  logic [VAL_W-1:0]  after_val, after_val_next;
  logic [VAL_W-1:0]  prev_val, prev_val_next;
  logic              pending, pending_next;
  logic              ovf, ovf_next;
  logic              accept;

  assign accept = push && !q_full;

  always_comb begin
    position_next   = position;
    best_pos_next   = best_pos;
    best_val_next   = best_val;
    before_val_next = before_val;
    after_val_next  = after_val;
    prev_val_next   = prev_val;
    pending_next    = pending;
    ovf_next        = ovf;
    rec_push        = 1'b0;
    if (accept) begin
      if (position >= PCNT_W'(MAX_LEN)) begin
        ovf_next = 1'b1;
      end else begin
        if (position == '0 || curve_value < best_val) begin
          best_val_next   = curve_value;
          best_pos_next   = position[POS_W-1:0];
          before_val_next = prev_val;
          pending_next    = 1'b1;
        end else if (pending) begin
          after_val_next = curve_value;
          pending_next   = 1'b0;
        end
        prev_val_next = curve_value;
        position_next = position + PCNT_W'(1);
      end
      rec_push = last;
    end
  end

  always_comb begin
    rec.val_before = before_val_next;
    rec.val_min    = best_val_next;
    rec.val_after  = after_val_next;
    rec.min_pos    = KIDX_W'(best_pos_next);
    rec.pending    = pending_next;
    rec.overflow   = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst || rec_push) begin
      position   <= '0;
      best_pos   <= '0;
      best_val   <= '0;
      before_val <= '0;
      after_val  <= '0;
      prev_val   <= '0;
      pending    <= 1'b0;
      ovf        <= 1'b0;
    end else begin
      position   <= position_next;
      best_pos   <= best_pos_next;
      best_val   <= best_val_next;
      before_val <= before_val_next;
      after_val  <= after_val_next;
      prev_val   <= prev_val_next;
      pending    <= pending_next;
      ovf        <= ovf_next;
    end
  end

endmodule

// File: hdl/pmi_queue.sv
// Two-entry queue of closed sequences between the front end and the back end.
module pmi_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  pmi_pkg::trough_t wr_data,
  input  logic             rd_en,
  output pmi_pkg::trough_t rd_data,
  output logic             full,
  output logic             empty
);
  import pmi_pkg::*;

  trough_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/pmi_back.sv
// Back end: parabola correction by restoring division and the result register.
module pmi_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  pmi_pkg::trough_t           q_data,
  output logic                       q_pop,
  input  logic                       pop,
  output logic                       out_valid,
  output logic [pmi_pkg::IDX_W-1:0]  min_index,
  output logic [pmi_pkg::REF_W-1:0]  refined_index,
  output logic                       interpolated,
  output logic                       too_long
);
  import pmi_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  back_state_t state, state_next;

  trough_t            rec;
  logic signed [33:0] den;
  logic signed [32:0] num;
  logic [33:0]        dvs;
  logic [34:0]        rem;
  logic [FRAC_BITS:0] quo;
  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic               do_interp;

  // Setup and magnitude terms.
  logic signed [33:0] den_calc;
  logic signed [32:0] num_calc;
  logic signed [32:0] num_neg;
  logic signed [33:0] den_neg;
  logic [31:0]        un;
  logic [32:0]        ud;
  logic [33:0]        dvs_calc;
  logic               big;
  logic               interp_ok;

  // Division step and final assembly.
  logic               ge;
  logic [34:0]        rem_sub;
  logic [FRAC_BITS:0] mag;
  logic [31:0]        base;
  logic [REF_W-1:0]   refined;
  logic               load;

  assign den_calc  = $signed({2'b00, rec.val_before}) - $signed({1'b0, rec.val_min, 1'b0})
                   + $signed({2'b00, rec.val_after});
  assign num_calc  = $signed({1'b0, rec.val_before}) - $signed({1'b0, rec.val_after});
  assign num_neg   = -num;
  assign den_neg   = -den;
  assign un        = num[32] ? num_neg[31:0] : num[31:0];
  assign ud        = den[33] ? den_neg[32:0] : den[32:0];
  assign dvs_calc  = {ud, 1'b0};
  assign big       = {3'b000, un} >= {dvs_calc, 1'b0};
  assign interp_ok = (rec.min_pos != '0) && !rec.pending && (den != '0);

  assign ge      = rem >= {1'b0, dvs};
  assign rem_sub = ge ? (rem - {1'b0, dvs}) : rem;

  assign mag     = (quo > ONE) ? ONE : quo;
  assign base    = 32'(rec.min_pos) << FRAC_BITS;
  assign refined = neg ? (base[REF_W-1:0] - REF_W'(mag)) : (base[REF_W-1:0] + REF_W'(mag));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load       = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BK_SETUP;
        end
      end
      BK_SETUP: begin
        state_next = BK_PREP;
      end
      BK_PREP: begin
        if (interp_ok && !big) begin
          state_next = BK_DIV;
        end else begin
          state_next = BK_DONE;
        end
      end
      BK_DIV: begin
        if (cnt == '0) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid || pop) begin
          load       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        rec <= q_data;
      end
      BK_SETUP: begin
        den <= den_calc;
        num <= num_calc;
      end
      BK_PREP: begin
        neg       <= num[32] ^ den[33];
        do_interp <= interp_ok;
        dvs       <= dvs_calc;
        rem       <= 35'(un);
        cnt       <= CNT_W'(FRAC_BITS);
        if (!interp_ok) begin
          quo <= '0;
        end else if (big) begin
          quo <= ONE;
        end else begin
          quo <= '0;
        end
      end
      BK_DIV: begin
        quo <= {quo[FRAC_BITS-1:0], ge};
        rem <= {rem_sub[33:0], 1'b0};
        cnt <= cnt - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      min_index     <= rec.min_pos[IDX_W-1:0];
      refined_index <= refined;
      interpolated  <= do_interp;
      too_long      <= rec.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: hdl/parabolic_min_interpolator.sv
// Top level of the parabolic minimum interpolator: front end, queue and divider back end.
//
//   Channel   Direction  Handshake         Transaction carries
//   input     in         push / full       curve_value, last
//   result    out        pop / empty       min_index, refined_index, interpolated, too_long
//
// The front end takes one curve sample per cycle whenever full is low. Full rises only
// when two closed sequences are already waiting for the back end. For each sequence the
// back end dequeues it, forms the numerator and denominator, takes magnitudes, runs
// FRAC_BITS + 1 restoring-division steps and loads the result register once it is free
// (fallback and clamp cases skip the division steps).
// Reset is synchronous and clears all control state; a waiting result holds until popped.
module parabolic_min_interpolator #(
  parameter int MAX_LEN   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [pmi_pkg::VAL_W-1:0]  curve_value,
  input  logic                       last,
  output logic                       empty,
  input  logic                       pop,
  output logic [pmi_pkg::IDX_W-1:0]  min_index,
  output logic [pmi_pkg::REF_W-1:0]  refined_index,
  output logic                       interpolated,
  output logic                       too_long
);
  import pmi_pkg::*;

  // A closed sequence travels from the front end to the back end through this queue.
  trough_t rec_in;
  trough_t rec_out;
  logic    rec_push;
  logic    rec_pop;
  logic    q_full;
  logic    q_empty;
  logic    out_valid;

  // Any sample may be the last of its sequence, so input stalls whenever the queue
  // could not take one more closed sequence.
  assign full  = q_full;
  assign empty = !out_valid;

  pmi_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .curve_value (curve_value),
    .last        (last),
    .q_full      (q_full),
    .rec_push    (rec_push),
    .rec         (rec_in)
  );

  pmi_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (rec_in),
    .rd_en   (rec_pop),
    .rd_data (rec_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  // The back end owns the result register, so a finished result can wait for pop while
  // the front end keeps collecting the next sequence.
  pmi_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (rec_out),
    .q_pop         (rec_pop),
    .pop           (pop),
    .out_valid     (out_valid),
    .min_index     (min_index),
    .refined_index (refined_index),
    .interpolated  (interpolated),
    .too_long      (too_long)
  );

endmodule

// File: hdl/pmi_port_checks.sv
// Port-level assertions for the parabolic minimum interpolator and their bind.
module pmi_port_checks #(
  parameter int FRAC_BITS = 8
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [pmi_pkg::IDX_W-1:0]  min_index,
  input logic [pmi_pkg::REF_W-1:0]  refined_index,
  input logic                       interpolated,
  input logic                       too_long
);

  // Reset leaves no stale result behind.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result visible right after reset");

  // Reset leaves the input side open.
  a_reset_open: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked right after reset");

  // A result that is not taken stays in place unchanged.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(min_index) && $stable(refined_index)
                          && $stable(interpolated) && $stable(too_long)))
    else $error("waiting result changed before pop");

  // Without interpolation the refined position is a whole sample.
  a_fallback_whole: assert property (@(posedge clk) disable iff (rst)
    (!empty && !interpolated) |-> (refined_index[FRAC_BITS-1:0] == '0))
    else $error("fallback result carries a fraction");

endmodule

bind parabolic_min_interpolator pmi_port_checks #(
  .FRAC_BITS (FRAC_BITS)
) u_port_checks (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .min_index     (min_index),
  .refined_index (refined_index),
  .interpolated  (interpolated),
  .too_long      (too_long)
);
